// ===== hw/rtl/qops_pkg.sv =====
// ----------------------------------------------------------------------------
// qops_pkg
// Types, widths and index tables for the quadric optimal point solver.
// ----------------------------------------------------------------------------
package qops_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int THR_W         = 63;
   // exact determinant and numerators stay below 2^96 in magnitude
   localparam int SUM_W         = 98;
   localparam int MAG_W         = SUM_W - 1;
   localparam int QUO_W         = 32;

   typedef struct packed {
      logic signed [31:0] m00;
      logic signed [31:0] m01;
      logic signed [31:0] m02;
      logic signed [31:0] m10;
      logic signed [31:0] m11;
      logic signed [31:0] m12;
      logic signed [31:0] m20;
      logic signed [31:0] m21;
      logic signed [31:0] m22;
      logic signed [31:0] c0;
      logic signed [31:0] c1;
      logic signed [31:0] c2;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic               solvable;
   } rsp_type;

   // matrix operands of the eighteen 2x2 products, two per cofactor
   // cofactor order: C00 C01 C02 C10 C11 C12 C20 C21 C22
   localparam logic [3:0] PROD_A [18] = '{4, 5, 5, 3, 3, 4, 2, 1, 0,
                                           2, 1, 0, 1, 2, 2, 0, 0, 1};
   localparam logic [3:0] PROD_B [18] = '{8, 7, 6, 8, 7, 6, 7, 8, 8,
                                           6, 6, 7, 5, 4, 3, 5, 4, 3};

   // coefficient of term t (lanes: det, x, y, z; three terms each)
   function automatic logic [2:0] term_coef(input logic [3:0] t);
      logic [1:0] lane;
      logic [1:0] idx;
      lane = 2'(t / 3);
      idx  = 2'(t % 3);
      term_coef = (lane == 2'd0) ? 3'(idx) : 3'(idx) + 3'd3;
   endfunction

   // cofactor of term t
   function automatic logic [3:0] term_cof(input logic [3:0] t);
      logic [1:0] lane;
      logic [1:0] idx;
      lane = 2'(t / 3);
      idx  = 2'(t % 3);
      term_cof = (lane == 2'd0) ? 4'(idx) : 4'(idx * 3 + lane - 2'd1);
   endfunction

endpackage

// ===== hw/rtl/quadric_optimal_point_solve_core.sv =====
// ----------------------------------------------------------------------------
// quadric_optimal_point_solve_core
// Solves A * p = -c for an error quadric by Cramer's rule, fixed point.
// ----------------------------------------------------------------------------
// Pipeline from start to rsp_valid: 7 arithmetic stages,
//   32 restoring-division stages of one quotient bit each, 1 output stage.
// Throughput: one item per cycle; busy stays low, the receiver cannot stall.
// Reset: synchronous, clears all valid bits; det_threshold returns to 1.
module quadric_optimal_point_solve_core
   import qops_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  req_type          req_data,
   output logic             rsp_valid,
   output rsp_type          rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [THR_W-1:0] csr_data
);

   localparam int NDIV = QUO_W;

   logic [THR_W-1:0] thr_ff;

   logic                    v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic signed [63:0]      prod_ff [18];
   logic signed [32:0]      coef1_ff [6];
   logic signed [64:0]      cof_ff [9];
   logic signed [32:0]      coef2_ff [6];
   logic signed [65:0]      pp_lo_ff [12];
   logic signed [65:0]      pp_hi_ff [12];
   logic signed [SUM_W-1:0] term_ff [12];
   logic signed [SUM_W-1:0] sum_ff [4];
   logic [63:0]             dmag6_ff;
   logic                    sol6_ff;
   logic [MAG_W-1:0]        mag6_ff [3];
   logic                    neg6_ff [3];

   // division pipeline, index 0 fed by the overflow stage
   logic                    dv_ff  [NDIV+1];
   logic [63:0]             dd_ff  [NDIV+1];
   logic                    ds_ff  [NDIV+1];
   logic [MAG_W-1:0]        dr_ff  [NDIV+1][3];
   logic [QUO_W-1:0]        dq_ff  [NDIV+1][3];
   logic                    dn_ff  [NDIV+1][3];
   logic                    do_ff  [NDIV+1][3];

   logic                    rv_ff;
   rsp_type                 rsp_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign rsp_valid = rv_ff;
   assign rsp_data  = rsp_ff;

   // hold threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_W'(1);
      end else if (csr_valid) begin
         thr_ff <= csr_data;
      end
   end

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0;
         v4_ff <= 1'b0; v5_ff <= 1'b0; v6_ff <= 1'b0;
         rv_ff <= 1'b0;
         for (int i = 0; i <= NDIV; i++) dv_ff[i] <= 1'b0;
      end else begin
         v1_ff <= start; v2_ff <= v1_ff; v3_ff <= v2_ff;
         v4_ff <= v3_ff; v5_ff <= v4_ff; v6_ff <= v5_ff;
         dv_ff[0] <= v6_ff;
         for (int i = 0; i < NDIV; i++) dv_ff[i+1] <= dv_ff[i];
         rv_ff <= dv_ff[NDIV];
      end
   end

   // stage 1: 2x2 products
   logic signed [31:0] mat [9];
   assign mat = '{req_data.m00, req_data.m01, req_data.m02,
                  req_data.m10, req_data.m11, req_data.m12,
                  req_data.m20, req_data.m21, req_data.m22};

   always_ff @(posedge clock) begin
      for (int i = 0; i < 18; i++) begin
         prod_ff[i] <= mat[PROD_A[i]] * mat[PROD_B[i]];
      end
      for (int i = 0; i < 3; i++) begin
         coef1_ff[i] <= 33'(mat[i]);
      end
      coef1_ff[3] <= -33'(req_data.c0);
      coef1_ff[4] <= -33'(req_data.c1);
      coef1_ff[5] <= -33'(req_data.c2);
   end

   // stage 2: cofactors
   always_ff @(posedge clock) begin
      for (int i = 0; i < 9; i++) begin
         cof_ff[i] <= 65'(prod_ff[2*i]) - 65'(prod_ff[2*i+1]);
      end
      coef2_ff <= coef1_ff;
   end

   // stage 3: split each coefficient-cofactor product in two halves
   always_ff @(posedge clock) begin
      for (int t = 0; t < 12; t++) begin
         pp_lo_ff[t] <= 66'(coef2_ff[term_coef(4'(t))])
                        * 66'($signed({34'd0, cof_ff[term_cof(4'(t))][31:0]}));
         pp_hi_ff[t] <= 66'(coef2_ff[term_coef(4'(t))])
                        * 66'($signed(cof_ff[term_cof(4'(t))][64:32]));
      end
   end

   // stage 4: recombine halves
   always_ff @(posedge clock) begin
      for (int t = 0; t < 12; t++) begin
         term_ff[t] <= (SUM_W'(pp_hi_ff[t]) <<< 32) + SUM_W'(pp_lo_ff[t]);
      end
   end

   // stage 5: sum three terms per lane
   always_ff @(posedge clock) begin
      for (int l = 0; l < 4; l++) begin
         sum_ff[l] <= term_ff[3*l] + term_ff[3*l+1] + term_ff[3*l+2];
      end
   end

   // stage 6: rescale and saturate determinant, take magnitudes
   logic signed [SUM_W-1:0] det_sh;
   logic                    det_fits;
   logic                    det_neg;
   logic [63:0]             det_mag;

   always_comb begin
      det_sh   = sum_ff[0] >>> FRAC_BITS;
      det_neg  = det_sh[SUM_W-1];
      det_fits = (det_sh[SUM_W-1:63] == '0) || (det_sh[SUM_W-1:63] == '1);
      if (det_fits) begin
         det_mag = det_neg ? (64'd0 - det_sh[63:0]) : det_sh[63:0];
      end else begin
         det_mag = det_neg ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      dmag6_ff <= det_mag;
      sol6_ff  <= (det_mag != 64'd0) && (det_mag >= {1'b0, thr_ff});
      for (int l = 0; l < 3; l++) begin
         mag6_ff[l] <= sum_ff[l+1][SUM_W-1] ? MAG_W'(-sum_ff[l+1])
                                             : MAG_W'(sum_ff[l+1]);
         neg6_ff[l] <= sum_ff[l+1][SUM_W-1] ^ det_neg;
      end
   end

   // stage 7: detect quotients of 2^32 and above
   always_ff @(posedge clock) begin
      dd_ff[0] <= dmag6_ff;
      ds_ff[0] <= sol6_ff;
      for (int l = 0; l < 3; l++) begin
         dr_ff[0][l] <= mag6_ff[l];
         dq_ff[0][l] <= '0;
         dn_ff[0][l] <= neg6_ff[l];
         do_ff[0][l] <= mag6_ff[l] >= (MAG_W'(dmag6_ff) << QUO_W);
      end
   end

   // division stages: one quotient bit each, most significant first
   for (genvar j = 0; j < NDIV; j++) begin : g_div
      localparam int SH = NDIV - 1 - j;
      always_ff @(posedge clock) begin
         dd_ff[j+1] <= dd_ff[j];
         ds_ff[j+1] <= ds_ff[j];
         for (int l = 0; l < 3; l++) begin
            dn_ff[j+1][l] <= dn_ff[j][l];
            do_ff[j+1][l] <= do_ff[j][l];
            if (dr_ff[j][l] >= (MAG_W'(dd_ff[j]) << SH)) begin
               dr_ff[j+1][l] <= dr_ff[j][l] - (MAG_W'(dd_ff[j]) << SH);
               dq_ff[j+1][l] <= dq_ff[j][l] | (QUO_W'(1) << SH);
            end else begin
               dr_ff[j+1][l] <= dr_ff[j][l];
               dq_ff[j+1][l] <= dq_ff[j][l];
            end
         end
      end
   end

   // output stage: apply sign, saturate, zero when singular
   logic [QUO_W-1:0] pos_res [3];

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         if (!ds_ff[NDIV]) begin
            pos_res[l] = '0;
         end else if (dn_ff[NDIV][l]) begin
            pos_res[l] = (do_ff[NDIV][l] || dq_ff[NDIV][l] > 32'h8000_0000)
                         ? 32'h8000_0000 : (32'd0 - dq_ff[NDIV][l]);
         end else begin
            pos_res[l] = (do_ff[NDIV][l] || dq_ff[NDIV][l] > 32'h7FFF_FFFF)
                         ? 32'h7FFF_FFFF : dq_ff[NDIV][l];
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff.pos_x    <= pos_res[0];
      rsp_ff.pos_y    <= pos_res[1];
      rsp_ff.pos_z    <= pos_res[2];
      rsp_ff.solvable <= ds_ff[NDIV];
   end

`ifndef SYNTHESIS
   a_singular_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.solvable |->
         rsp_data.pos_x == 0 && rsp_data.pos_y == 0 && rsp_data.pos_z == 0)
      else $error("singular item with nonzero position");

   a_valid_chain : assert property (@(posedge clock) disable iff (reset)
      dv_ff[NDIV] |=> rsp_valid)
      else $error("item lost at output stage");

   a_sat_overflow : assert property (@(posedge clock) disable iff (reset)
      dv_ff[NDIV] && ds_ff[NDIV] && do_ff[NDIV][0] && !dn_ff[NDIV][0] |=>
         rsp_data.pos_x == 32'sh7FFF_FFFF)
      else $error("overflowed quotient not saturated");
`endif

endmodule

// ===== test/quadric_optimal_point_solve_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadric_optimal_point_solve_core_tb
// Self-checking bench for the quadric optimal point solver. A directed table
// covers identity, zero and extreme matrices; random quadrics follow under
// several determinant thresholds and sender gap rates. Every position is
// checked against an exact wide-integer Cramer's rule solver kept here.
// ----------------------------------------------------------------------------
module quadric_optimal_point_solve_core_tb;
   import qops_pkg::*;

   localparam int FRAC     = 16;
   localparam int DRAIN    = 45;
   localparam int WDOG_MAX = 5000;
   localparam int N_PHASE  = 5;
   localparam int N_RAND   = 228;

   localparam logic signed [127:0] DET_MAX = 128'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [127:0] DET_MIN = -DET_MAX - 128'sd1;

   typedef struct {
      req_type    item;
      logic       known;
      rsp_type    pos;
   } vec_type;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   req_type          req_data;
   logic             rsp_valid;
   rsp_type          rsp_data;
   logic             csr_valid;
   logic             csr_ready;
   logic [THR_W-1:0] csr_data;

   rsp_type          expected_pos[$];
   logic [THR_W-1:0] threshold;
   int               fail_count;
   int               idle_cycles;

   quadric_optimal_point_solve_core DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // clock generation
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // exact determinant of a row-major 3x3 matrix
   function automatic logic signed [127:0] det_exact(input logic signed [127:0] m[9]);
      det_exact = m[0] * (m[4] * m[8] - m[5] * m[7])
                - m[1] * (m[3] * m[8] - m[5] * m[6])
                + m[2] * (m[3] * m[7] - m[4] * m[6]);
   endfunction

   // solve A * p = -c under the current threshold
   function automatic rsp_type solve_position(input req_type r);
      logic signed [127:0] a[9];
      logic signed [127:0] s[9];
      logic signed [127:0] rhs[3];
      logic signed [127:0] d;
      logic signed [127:0] num;
      logic [127:0]        nmag;
      logic [127:0]        q;
      logic [63:0]         dmag;
      logic                dneg;
      logic [31:0]         coord[3];
      rsp_type             res;
      a = '{r.m00, r.m01, r.m02, r.m10, r.m11, r.m12, r.m20, r.m21, r.m22};
      rhs[0] = -128'(signed'(r.c0));
      rhs[1] = -128'(signed'(r.c1));
      rhs[2] = -128'(signed'(r.c2));
      d = det_exact(a) >>> FRAC;
      if (d > DET_MAX) begin
         dneg = 1'b0;
         dmag = 64'h7FFF_FFFF_FFFF_FFFF;
      end else if (d < DET_MIN) begin
         dneg = 1'b1;
         dmag = 64'h8000_0000_0000_0000;
      end else begin
         dneg = d < 0;
         dmag = dneg ? 64'(-d) : 64'(d);
      end
      res = '0;
      if (dmag == 64'd0 || dmag < {1'b0, threshold}) return res;
      for (int k = 0; k < 3; k++) begin
         s = a;
         for (int i = 0; i < 3; i++) s[i * 3 + k] = rhs[i];
         num  = det_exact(s);
         nmag = num < 0 ? 128'(-num) : 128'(num);
         q    = nmag / {64'd0, dmag};
         if ((num < 0) != dneg)
            coord[k] = (q > 128'h8000_0000) ? 32'h8000_0000 : 32'(-q);
         else
            coord[k] = (q > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : 32'(q);
      end
      res.pos_x    = coord[0];
      res.pos_y    = coord[1];
      res.pos_z    = coord[2];
      res.solvable = 1'b1;
      return res;
   endfunction

   // random matrix entry: full range, moderate or small
   function automatic logic [31:0] rand_entry(input int kind);
      case (kind)
         0: rand_entry = $urandom;
         1: rand_entry = 32'($signed($urandom_range(32'h3FFFF)) - 32'sh1FFFF);
         default: rand_entry = 32'($signed($urandom_range(32'h7FF)) - 32'sh3FF);
      endcase
   endfunction

   function automatic req_type rand_quadric();
      req_type r;
      int      kind;
      int      shape;
      kind  = $urandom_range(2);
      shape = $urandom_range(9);
      r.m00 = rand_entry(kind); r.m01 = rand_entry(kind); r.m02 = rand_entry(kind);
      r.m10 = rand_entry(kind); r.m11 = rand_entry(kind); r.m12 = rand_entry(kind);
      r.m20 = rand_entry(kind); r.m21 = rand_entry(kind); r.m22 = rand_entry(kind);
      r.c0  = rand_entry($urandom_range(2));
      r.c1  = rand_entry($urandom_range(2));
      r.c2  = rand_entry($urandom_range(2));
      // dependent rows give a zero determinant
      if (shape == 0) begin
         r.m20 = r.m00; r.m21 = r.m01; r.m22 = r.m02;
      end
      // symmetric; diagonally dominant and well-conditioned unless entries are full range
      if (shape >= 6) begin
         r.m10 = r.m01; r.m20 = r.m02; r.m21 = r.m12;
         r.m00 = 32'($signed($urandom_range(32'h7FFFF)) + 32'sh40000);
         r.m11 = 32'($signed($urandom_range(32'h7FFFF)) + 32'sh40000);
         r.m22 = 32'($signed($urandom_range(32'h7FFFF)) + 32'sh40000);
      end
      return r;
   endfunction

   // present one item, hold until accepted, record its expected position
   task automatic send_item(input req_type r, input int gap_pct);
      while ($urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_pos.push_back(solve_position(r));
   endtask

   // drain, wait out the pipeline, then write the threshold
   task automatic write_threshold(input logic [THR_W-1:0] value);
      start <= 1'b0;
      while (expected_pos.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      threshold = value;
   endtask

   // check each result against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_pos.size() == 0) begin
            $error("unexpected result: %h", rsp_data);
            fail_count++;
         end else begin
            rsp_type e;
            e = expected_pos.pop_front();
            if (rsp_data.pos_x !== e.pos_x) begin
               $error("pos_x expected %h actual %h", e.pos_x, rsp_data.pos_x);
               fail_count++;
            end
            if (rsp_data.pos_y !== e.pos_y) begin
               $error("pos_y expected %h actual %h", e.pos_y, rsp_data.pos_y);
               fail_count++;
            end
            if (rsp_data.pos_z !== e.pos_z) begin
               $error("pos_z expected %h actual %h", e.pos_z, rsp_data.pos_z);
               fail_count++;
            end
            if (rsp_data.solvable !== e.solvable) begin
               $error("solvable expected %b actual %b", e.solvable, rsp_data.solvable);
               fail_count++;
            end
         end
      end
   end

   // watchdog: count cycles without any handshake
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_MAX) begin
         $display("quadric_optimal_point_solve_core: mismatch");
         $finish;
      end
   end

   // stimulus
   initial begin
      vec_type          dir_vec[$];
      vec_type          v;
      logic [THR_W-1:0] phase_thr[N_PHASE];
      int               gap_pct;
      reset       = 1'b1;
      start       = 1'b0;
      req_data    = '0;
      csr_valid   = 1'b0;
      csr_data    = '0;
      threshold   = 63'd1;
      fail_count  = 0;
      idle_cycles = 0;

      // directed rows
      v.known = 1'b1;
      v.item  = '0;
      v.pos   = '0;
      dir_vec.push_back(v);
      v.item = '{32'sh10000, 0, 0, 0, 32'sh10000, 0, 0, 0, 32'sh10000,
                 -32'sh10000, -32'sh20000, -32'sh30000};
      v.pos  = '{32'sh10000, 32'sh20000, 32'sh30000, 1'b1};
      dir_vec.push_back(v);
      // determinant below one lsb of Q32.32 truncates to zero
      v.item = '{1, 0, 0, 0, 1, 0, 0, 0, 1, 5, 5, 5};
      v.pos  = '0;
      dir_vec.push_back(v);
      v.known = 1'b0;
      // saturated determinant, both signs
      v.item = '{32'h7FFFFFFF, 0, 0, 0, 32'h7FFFFFFF, 0, 0, 0, 32'h7FFFFFFF,
                 32'h80000000, 32'h7FFFFFFF, 1};
      dir_vec.push_back(v);
      v.item = '{32'h80000000, 0, 0, 0, 32'h7FFFFFFF, 0, 0, 0, 32'h7FFFFFFF,
                 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF};
      dir_vec.push_back(v);
      // quotient overflow both ways
      v.item = '{32'sh100, 0, 0, 0, 32'sh100, 0, 0, 0, 32'sh100,
                 32'h80000000, 32'h7FFFFFFF, 32'h80000000};
      dir_vec.push_back(v);
      v.item = '{-32'sh100, 0, 0, 0, 32'sh100, 0, 0, 0, 32'sh100,
                 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF};
      dir_vec.push_back(v);
      // all fields at extremes, then mixed rows
      v.item = '{12{32'h7FFFFFFF}};
      dir_vec.push_back(v);
      v.item = '{12{32'h80000000}};
      dir_vec.push_back(v);
      v.item = '{32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
                 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF};
      dir_vec.push_back(v);
      v.item = '{32'hFFFFFFFF, 32'h1, 32'h2, 32'h3, 32'hFFFFFFFF, 32'h5, 32'h6, 32'h7,
                 32'hFFFFFFFF, 32'h55555555, 32'hAAAAAAAA, 32'h0};
      dir_vec.push_back(v);
      v.item = '{32'sh30000, -32'sh8000, 32'sh1000, -32'sh8000, 32'sh28000, 32'sh2000,
                 32'sh1000, 32'sh2000, 32'sh20000, 32'sh12345, -32'sh6789A, 32'sh7777};
      dir_vec.push_back(v);

      phase_thr = '{63'd1, 63'd0, 63'h7FFF_FFFF_FFFF_FFFF, 63'h1_0000_0000, '0};
      phase_thr[4] = THR_W'({$urandom_range(32'h3FF), $urandom});

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table under the reset threshold
      foreach (dir_vec[i]) begin
         send_item(dir_vec[i].item, 0);
         if (dir_vec[i].known && expected_pos[$] !== dir_vec[i].pos) begin
            $error("table row %0d: expected %h computed %h", i, dir_vec[i].pos,
                   expected_pos[$]);
            fail_count++;
         end
      end

      // random phases over thresholds and gap rates
      for (int p = 0; p < N_PHASE; p++) begin
         write_threshold(phase_thr[p]);
         if (p == 1) begin
            // zero determinant stays singular at threshold zero
            send_item('{32'sh10000, 32'sh20000, 32'sh30000, 32'sh10000, 32'sh20000,
                        32'sh30000, 32'sh5, 32'sh6, 32'sh7, 32'sh1, 32'sh2, 32'sh3}, 0);
         end
         gap_pct = (p < 2) ? 6 : ((p < 4) ? 59 : 0);
         for (int n = 0; n < N_RAND; n++) send_item(rand_quadric(), gap_pct);
      end
      start <= 1'b0;

      while (expected_pos.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (fail_count == 0)
         $display("quadric_optimal_point_solve_core: match");
      else
         $display("quadric_optimal_point_solve_core: mismatch");
      $finish;
   end

endmodule
